@@ rtl/uet_pkg.sv @@
// Shared types and constants for the ultrasonic echo timer.
// Used by uet_core and ultrasonic_echo_timer; depends on nothing.
package uet_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_EDGE  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    // result status carried on the output tuser
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_THREE   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    // measurement phase, one-hot
    typedef enum logic [2:0] {
        PH_NONE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_ECHO = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    // configuration reset values
    localparam logic [15:0] MAX_ECHO_RESET = 16'd30000;
    localparam logic [15:0] WINDOW_RESET   = 16'd1000;
    localparam logic [7:0]  LIMIT_RESET    = 8'd10;

    localparam logic [7:0] TIMEOUTS_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] echo_max;
        logic [15:0] timeout_window;
        logic [7:0]  timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] period;
        status_t     status;
    } res_t;

endpackage

@@ rtl/uet_core.sv @@
// Measurement state and per-beat update for the ultrasonic echo timer.
// Depends on uet_pkg; result is combinational for the beat being processed.
module uet_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [1:0]        opcode,
    input  logic [31:0]       capture_time,
    input  uet_pkg::cfg_t     cfg,
    output uet_pkg::res_t     res
);

    logic            armed_reg, armed_next;
    uet_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     first_reg, first_next;
    logic [31:0]     second_reg, second_next;
    logic [31:0]     period1_reg, period1_next;
    logic [15:0]     idle_reg, idle_next;
    logic [7:0]      timeouts_reg, timeouts_next;

    logic [31:0] diff_first;
    logic [31:0] diff_second;
    logic [16:0] elapsed;
    logic [7:0]  timeouts_inc;

    // period arithmetic, modulo 2^32
    assign diff_first  = capture_time - first_reg;
    assign diff_second = capture_time - second_reg;
    assign elapsed     = {1'b0, idle_reg} + 17'd1;

    // next-state and result for one beat
    always_comb
    begin
        armed_next    = armed_reg;
        phase_next    = phase_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        period1_next  = period1_reg;
        idle_next     = idle_reg;
        timeouts_next = timeouts_reg;
        timeouts_inc  = timeouts_reg;
        res           = '0;
        if (fire)
        begin
            case (opcode)
                uet_pkg::OP_START:
                begin
                    armed_next    = 1'b1;
                    phase_next    = uet_pkg::PH_NONE;
                    idle_next     = '0;
                    timeouts_next = '0;
                end
                uet_pkg::OP_EDGE:
                begin
                    if (armed_reg)
                    begin
                        idle_next     = '0;
                        timeouts_next = '0;
                        case (phase_reg)
                            uet_pkg::PH_NONE:
                            begin
                                first_next = capture_time;
                                phase_next = uet_pkg::PH_FIRST;
                            end
                            uet_pkg::PH_FIRST:
                            begin
                                second_next = capture_time;
                                if (diff_first <= {16'd0, cfg.echo_max})
                                begin
                                    res.valid  = 1'b1;
                                    res.period = diff_first;
                                    res.status = uet_pkg::ST_GOOD;
                                    armed_next = 1'b0;
                                    phase_next = uet_pkg::PH_NONE;
                                end
                                else
                                begin
                                    period1_next = diff_first;
                                    phase_next   = uet_pkg::PH_SECOND;
                                end
                            end
                            uet_pkg::PH_SECOND:
                            begin
                                res.valid  = 1'b1;
                                res.period = (period1_reg > diff_second) ? diff_second
                                                                         : period1_reg;
                                res.status = uet_pkg::ST_THREE;
                                armed_next = 1'b0;
                                phase_next = uet_pkg::PH_NONE;
                            end
                            default:
                            begin
                                phase_next = uet_pkg::PH_NONE;
                            end
                        endcase
                    end
                end
                uet_pkg::OP_TICK:
                begin
                    if (armed_reg)
                    begin
                        // window expiry counts one timeout, saturating
                        if (elapsed > {1'b0, cfg.timeout_window})
                        begin
                            idle_next = '0;
                            if (timeouts_reg != uet_pkg::TIMEOUTS_MAX)
                            begin
                                timeouts_inc = timeouts_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            idle_next = elapsed[15:0];
                        end
                        timeouts_next = timeouts_inc;
                        if (timeouts_inc >= cfg.timeout_limit)
                        begin
                            res.valid  = 1'b1;
                            res.period = '0;
                            res.status = uet_pkg::ST_TIMEOUT;
                            armed_next = 1'b0;
                            phase_next = uet_pkg::PH_NONE;
                        end
                    end
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b0;
            phase_reg    <= uet_pkg::PH_NONE;
            idle_reg     <= '0;
            timeouts_reg <= '0;
        end
        else
        begin
            armed_reg    <= armed_next;
            phase_reg    <= phase_next;
            idle_reg     <= idle_next;
            timeouts_reg <= timeouts_next;
        end
    end

    // edge times
    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        second_reg  <= second_next;
        period1_reg <= period1_next;
    end

    // every result ends the measurement
    a_result_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> !armed_reg && phase_reg == uet_pkg::PH_NONE)
        else $error("block still armed after a result");

    // a good period never exceeds the maximum echo time
    a_good_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == uet_pkg::ST_GOOD
        |-> res.period <= {16'd0, cfg.echo_max})
        else $error("good period above maximum echo time");

    // failure reports zero period
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == uet_pkg::ST_TIMEOUT |-> res.period == '0)
        else $error("timeout result with nonzero period");

    // no result without being armed
    a_result_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> armed_reg && fire)
        else $error("result while not armed");

endmodule

@@ rtl/ultrasonic_echo_timer.sv @@
// Ultrasonic echo timer: takes one beat per cycle, back to back. A beat is held
// in the input register while uet_core updates the measurement state and
// forms any result, which lands in the output register; a result is presented
// on the output from that register. The state update in uet_core sets the rate,
// one beat per clock whenever the output side keeps up.
// Top level; depends on uet_pkg and uet_core.
module ultrasonic_echo_timer
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] capture_time
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] echo_period
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    uet_pkg::cfg_t cfg_reg;
    uet_pkg::res_t res;

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [31:0] in_time_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_period_reg;
    logic [1:0]  out_status_reg;
    logic        advance;
    logic        fire;
    logic        accept;

    // pipeline handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.echo_max       <= uet_pkg::MAX_ECHO_RESET;
            cfg_reg.timeout_window <= uet_pkg::WINDOW_RESET;
            cfg_reg.timeout_limit  <= uet_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uet_pkg::REG_MAX_ECHO: cfg_reg.echo_max       <= cfg_wdata;
                uet_pkg::REG_WINDOW:   cfg_reg.timeout_window <= cfg_wdata;
                uet_pkg::REG_LIMIT:    cfg_reg.timeout_limit  <= cfg_wdata[7:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= s_axis_tuser;
            in_time_reg <= s_axis_tdata;
        end
    end

    uet_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .opcode       (in_op_reg),
        .capture_time (in_time_reg),
        .cfg          (cfg_reg),
        .res          (res)
    );

    // output register
    assign out_valid_next = advance ? res.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_period_reg <= res.period;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_period_reg;
    assign m_axis_tuser  = out_status_reg;

    // a beat held in the input register is not dropped while the output stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat lost during stall");

    // a pending result is not overwritten while stalled
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_period_reg))
        else $error("pending result overwritten");

    // the core only processes a beat when the output can take its result
    a_fire_space: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> advance)
        else $error("result formed with no room");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_echo_timer: directed and random beats,
// predicted results held by a small scoreboard class. Depends on uet_pkg and the RTL.
module tb_top;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    // predicts echo measurements and holds the results still due from the block
    class echo_scoreboard;
        logic [15:0]      max_echo;
        logic [15:0]      window_len;
        logic [7:0]       fail_limit;
        bit               armed;
        uet_pkg::phase_t  ph;
        logic [31:0]      t_first;
        logic [31:0]      t_second;
        logic [15:0]      idle_ticks;
        logic [7:0]       timeouts;
        logic [31:0]      period_q[$];
        uet_pkg::status_t status_q[$];
        int               errors;

        function new();
            max_echo   = uet_pkg::MAX_ECHO_RESET;
            window_len = uet_pkg::WINDOW_RESET;
            fail_limit = uet_pkg::LIMIT_RESET;
            armed      = 1'b0;
            ph         = uet_pkg::PH_NONE;
            t_first    = '0;
            t_second   = '0;
            idle_ticks = '0;
            timeouts   = '0;
            errors     = 0;
        endfunction

        function int pending();
            return period_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns  MISMATCH  %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == uet_pkg::REG_MAX_ECHO)
                max_echo = val;
            else if (idx == uet_pkg::REG_WINDOW)
                window_len = val;
            else if (idx == uet_pkg::REG_LIMIT)
                fail_limit = val[7:0];
        endfunction

        // every result ends the measurement
        function void emit(logic [31:0] period, uet_pkg::status_t st);
            period_q.push_back(period);
            status_q.push_back(st);
            armed = 1'b0;
            ph    = uet_pkg::PH_NONE;
        endfunction

        function void note_beat(logic [1:0] op, logic [31:0] t);
            logic [31:0] p1;
            logic [31:0] p2;
            logic [16:0] elapsed;
            if (op == uet_pkg::OP_START)
            begin
                armed      = 1'b1;
                ph         = uet_pkg::PH_NONE;
                idle_ticks = '0;
                timeouts   = '0;
            end
            else if (!armed)
            begin
                // edges and ticks are dropped until a start arrives
            end
            else if (op == uet_pkg::OP_EDGE)
            begin
                idle_ticks = '0;
                timeouts   = '0;
                if (ph == uet_pkg::PH_NONE)
                begin
                    t_first = t;
                    ph      = uet_pkg::PH_FIRST;
                end
                else if (ph == uet_pkg::PH_FIRST)
                begin
                    t_second = t;
                    p1 = t_second - t_first;
                    if (p1 <= {16'd0, max_echo})
                        emit(p1, uet_pkg::ST_GOOD);
                    else
                        ph = uet_pkg::PH_SECOND;
                end
                else
                begin
                    // out of range pair: keep the shorter of the two periods
                    p1 = t_second - t_first;
                    p2 = t - t_second;
                    emit((p1 > p2) ? p2 : p1, uet_pkg::ST_THREE);
                end
            end
            else if (op == uet_pkg::OP_TICK)
            begin
                elapsed = {1'b0, idle_ticks} + 17'd1;
                if (elapsed > {1'b0, window_len})
                begin
                    idle_ticks = '0;
                    if (timeouts != uet_pkg::TIMEOUTS_MAX)
                        timeouts = timeouts + 8'd1;
                end
                else
                    idle_ticks = elapsed[15:0];
                if (timeouts >= fail_limit)
                    emit(32'd0, uet_pkg::ST_TIMEOUT);
            end
        endfunction

        task check_result(logic [31:0] period, logic [1:0] st);
            logic [31:0]      want_period;
            uet_pkg::status_t want_status;
            if (period_q.size() == 0)
                report_mismatch($sformatf("unexpected result period=%0d status=%0d",
                                          period, st));
            else
            begin
                want_period = period_q.pop_front();
                want_status = status_q.pop_front();
                if (period !== want_period)
                    report_mismatch($sformatf("echo_period %0d, expected %0d",
                                              period, want_period));
                if (st !== want_status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              st, want_status));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] capture_time
    logic [1:0]  s_axis_tuser;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] echo_period
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    echo_scoreboard sb;
    int unsigned    send_idle;
    int unsigned    recv_idle;
    int unsigned    beats_sent;
    bit             long_hold_req;

    ultrasonic_echo_timer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock, 20 ns period
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result side: random stalls plus one long hold on request
    initial
    begin : result_sink
        int unsigned hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold = 400;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // offer one beat, with a random gap first; returns at the falling edge
    task automatic send_beat(input logic [1:0] op, input logic [31:0] t);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(op, t);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n)
            send_beat(uet_pkg::OP_TICK, $urandom);
    endtask

    // ticks enough to run out the timeout budget, capped to keep runs short
    function automatic int unsigned ticks_to_fail();
        int unsigned n;
        n = (int'(sb.window_len) + 1) * int'(sb.fail_limit) + $urandom_range(2);
        return (n > 600) ? 600 : n;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] max_echo, input logic [15:0] window_len,
                              input logic [7:0] fail_limit);
        write_reg(uet_pkg::REG_MAX_ECHO, max_echo);
        write_reg(uet_pkg::REG_WINDOW, window_len);
        write_reg(uet_pkg::REG_LIMIT, {8'd0, fail_limit});
    endtask

    // wait for every due result, then let the pipeline run empty
    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0 && guard < 50000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    // one measurement with random content, mostly well formed
    task automatic run_measurement();
        int unsigned pick;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] d;
        pick = $urandom_range(99);
        send_beat(uet_pkg::OP_START, $urandom);
        if (pick < 5)
            send_beat(uet_pkg::OP_START, $urandom);
        send_ticks($urandom_range(3));
        if (pick >= 80 && pick < 88)
        begin
            send_ticks(ticks_to_fail());
            return;
        end
        t0 = $urandom;
        send_beat(uet_pkg::OP_EDGE, t0);
        if (pick >= 88)
        begin
            send_ticks(ticks_to_fail());
            return;
        end
        send_ticks($urandom_range(3));
        case ($urandom_range(4))
            0, 1:    d = $urandom_range(int'(sb.max_echo), 0);
            2:       d = {16'd0, sb.max_echo} + $urandom_range(1);
            3:       d = $urandom;
            default: d = {16'd0, sb.max_echo} + 32'd1 + $urandom_range(100000);
        endcase
        t1 = t0 + d;
        send_beat(uet_pkg::OP_EDGE, t1);
        if (d > {16'd0, sb.max_echo})
        begin
            send_ticks($urandom_range(3));
            if ($urandom_range(9) == 0)
                send_ticks(ticks_to_fail());
            else if ($urandom_range(3) == 0)
                send_beat(uet_pkg::OP_EDGE, $urandom);
            else
                send_beat(uet_pkg::OP_EDGE, t1 + $urandom_range(200000));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 4))
            send_beat(2'($urandom_range(3)), $urandom);
    endtask

    // stimulus
    initial
    begin : stimulus
        int phase_no;
        int unsigned target;
        sb = new();
        send_idle     = 0;
        recv_idle     = 0;
        beats_sent    = 0;
        long_hold_req = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: ignored beats while idle, boundary good and out-of-range pair
        send_beat(uet_pkg::OP_EDGE, 32'd5);
        send_beat(uet_pkg::OP_TICK, 32'd0);
        send_beat(OP_RESERVED, 32'hFFFF_FFFF);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd30000);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd30001);
        send_beat(uet_pkg::OP_EDGE, 32'd30006);
        drain();

        // small window: wrapped difference, zero period, timeout after one edge
        set_config(16'd100, 16'd2, 8'd2);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'hFFFF_FFF0);
        send_beat(uet_pkg::OP_EDGE, 32'h0000_0050);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'hFFFF_FFFF);
        send_beat(uet_pkg::OP_EDGE, 32'hFFFF_FFFF);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd7);
        send_ticks(6);
        drain();

        // zero window and zero limit fail on the first tick; unused index dropped
        set_config(16'd0, 16'd0, 8'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_TICK, 32'd0);
        send_beat(uet_pkg::OP_START, 32'd0);
        send_beat(uet_pkg::OP_EDGE, 32'd9);
        send_beat(uet_pkg::OP_EDGE, 32'd9);
        drain();

        // random phases over several settings and idle patterns
        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            if (phase_no < 2)
            begin
                send_idle = 29;
                recv_idle = 72;
            end
            else if (phase_no < 4)
            begin
                send_idle = 72;
                recv_idle = 29;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (phase_no)
                0: set_config(16'hFFFF, 16'd3, 8'd2);
                1: set_config(16'($urandom_range(2000)), 16'($urandom_range(1, 6)),
                              8'($urandom_range(1, 4)));
                2: set_config(16'd0, 16'hFFFF, 8'd255);
                3: set_config(16'($urandom_range(65535)), 16'd0, 8'd1);
                4: set_config(16'($urandom_range(2000)), 16'($urandom_range(1, 6)),
                              8'($urandom_range(1, 4)));
                default: set_config(16'd30000, 16'd1, 8'd255);
            endcase
            target = beats_sent + ((phase_no == 5) ? 300 : 250);
            if (phase_no == 4)
            begin
                // long output hold while short good measurements keep coming
                long_hold_req = 1'b1;
                repeat (40)
                begin
                    send_beat(uet_pkg::OP_START, $urandom);
                    send_beat(uet_pkg::OP_EDGE, 32'd1000);
                    send_beat(uet_pkg::OP_EDGE,
                              32'd1000 + $urandom_range(int'(sb.max_echo), 0));
                end
            end
            while (beats_sent < target)
            begin
                if ($urandom_range(9) < 8)
                    run_measurement();
                else
                    run_noise();
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** ultrasonic_echo_timer: PASSED **");
        else
            $display("** ultrasonic_echo_timer: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #(20 * 400000);
        $display("** ultrasonic_echo_timer: FAILED **");
        $finish;
    end

endmodule
